>>> rtl/periodic_repeat_suppressor_assert.svh
// Assertion macros for the periodic repeat suppressor checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef PERIODIC_REPEAT_SUPPRESSOR_ASSERT_SVH
`define PERIODIC_REPEAT_SUPPRESSOR_ASSERT_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/prs_pkg.sv
// Shared types, sizes and codes for the periodic repeat suppressor.
// No dependencies.
`default_nettype none
package prs_pkg;
  localparam int HISTORY_DEPTH    = 64;
  localparam int MAX_PERIOD_LIMIT = 16;
  localparam int TOK_W  = 51;
  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int FW     = $clog2(HISTORY_DEPTH + 1);
  localparam int LW     = $clog2(MAX_PERIOD_LIMIT + 1);
  localparam int PW     = (MAX_PERIOD_LIMIT > 1) ? $clog2(MAX_PERIOD_LIMIT) : 1;
  localparam int HSIZE_W = 7;
  localparam int MAXP_W  = 5;
  localparam int CNT_W   = 32;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 40;

  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_HSIZE  = 2'd1;
  localparam logic [1:0] CFG_MAXP   = 2'd2;

  typedef logic [TOK_W-1:0] token_t;

  typedef enum logic [1:0] {
    ACT_LOG  = 2'd0,
    ACT_DROP = 2'd1,
    ACT_SUM  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    EV_OFF, EV_DROP, EV_SUM, EV_LOG
  } ev_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_EVAL, OP_RD0, OP_SET1, OP_SETMAX, OP_CLRLEN, OP_LENDEC,
    OP_RDL, OP_PAIRINIT, OP_RDPAIR, OP_INCI, OP_DISTINIT, OP_RDDIST, OP_NEXTROW,
    OP_INCJ, OP_COPYINIT, OP_RDCOPY, OP_CWR, OP_FINISH, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_RD0, S_C0, S_LEN, S_LCMP, S_PAIR, S_PCMP,
    S_DIST, S_DCMP, S_COPY, S_CWR, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    ev_t  ev;
    logic fill_ge1;
    logic a_eq_cur;
    logic a_eq_b;
    logic len_lt2;
    logic fill_short;
    logic i_last;
    logic j_end;
    logic out_free;
  } dp_status_t;
endpackage
`default_nettype wire

>>> rtl/prs_ctrl.sv
// Sequencer for the suppressor: walks the pattern check and period search.
// Depends on prs_pkg; drives prs_datapath through dp_op_t commands.
`default_nettype none
module prs_ctrl
  import prs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t st,
  output dp_op_t          op
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op = OP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        op = OP_EVAL;
        if (st.ev == EV_OFF || st.ev == EV_DROP) state_nxt = S_OUT;
        else state_nxt = S_RD0;
      end
      S_RD0: begin
        if (st.fill_ge1) begin
          op = OP_RD0;
          state_nxt = S_C0;
        end else begin
          op = OP_SETMAX;
          state_nxt = S_LEN;
        end
      end
      S_C0: begin
        if (st.a_eq_cur) begin
          op = OP_SET1;
          state_nxt = S_FIN;
        end else begin
          op = OP_SETMAX;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (st.len_lt2) begin
          op = OP_CLRLEN;
          state_nxt = S_FIN;
        end else if (st.fill_short) begin
          op = OP_LENDEC;
        end else begin
          op = OP_RDL;
          state_nxt = S_LCMP;
        end
      end
      S_LCMP: begin
        if (st.a_eq_cur) begin
          op = OP_PAIRINIT;
          state_nxt = S_PAIR;
        end else begin
          op = OP_LENDEC;
          state_nxt = S_LEN;
        end
      end
      S_PAIR: begin
        if (st.i_last) begin
          op = OP_DISTINIT;
          state_nxt = S_DIST;
        end else begin
          op = OP_RDPAIR;
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (st.a_eq_b) begin
          op = OP_INCI;
          state_nxt = S_PAIR;
        end else begin
          op = OP_LENDEC;
          state_nxt = S_LEN;
        end
      end
      S_DIST: begin
        if (st.i_last) begin
          op = OP_COPYINIT;
          state_nxt = S_COPY;
        end else if (st.j_end) begin
          op = OP_NEXTROW;
        end else begin
          op = OP_RDDIST;
          state_nxt = S_DCMP;
        end
      end
      S_DCMP: begin
        if (st.a_eq_b) begin
          op = OP_LENDEC;
          state_nxt = S_LEN;
        end else begin
          op = OP_INCJ;
          state_nxt = S_DIST;
        end
      end
      S_COPY: begin
        if (st.i_last) begin
          state_nxt = S_FIN;
        end else begin
          op = OP_RDCOPY;
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        op = OP_CWR;
        state_nxt = S_COPY;
      end
      S_FIN: begin
        op = OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          op = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/prs_datapath.sv
// Datapath: config registers, history ring, pattern store, search counters,
// result and output registers. Depends on prs_pkg.
`default_nettype none
module prs_datapath
  import prs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [HSIZE_W-1:0] cfg_data,
  input  wire dp_op_t            op,
  output dp_status_t             st,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata
);
  localparam int CW = FW + LW + 2;

  logic               en_r;
  logic [HSIZE_W-1:0] hsize_r;
  logic [MAXP_W-1:0]  maxp_r;
  token_t             cur_r;
  token_t             ring [HISTORY_DEPTH];
  token_t             pat [MAX_PERIOD_LIMIT];
  token_t             rd_a_r, rd_b_r;
  logic [AW-1:0]      head_r;
  logic [FW-1:0]      fill_r;
  logic [LW-1:0]      period_r;
  logic [PW-1:0]      pos_r;
  logic [CNT_W-1:0]   rep_r;
  logic [LW-1:0]      len_r, i_r, j_r;
  logic [1:0]         res_act_r;
  logic [CNT_W-1:0]   res_cnt_r;
  logic [LW-1:0]      res_per_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic [FW-1:0]      eff_n;
  logic [LW-1:0]      emax;
  logic [FW-1:0]      back_a, back_b;
  logic [AW-1:0]      addr_a, addr_b;
  logic               active, stale, match;
  logic [LW-1:0]      pos_inc;

  function automatic logic [AW-1:0] hpos(input logic [AW-1:0] head,
                                         input logic [FW-1:0] n,
                                         input logic [FW-1:0] back);
    logic [FW:0] t;
    t = {1'b0, FW'(head)} + {1'b0, n} - (FW+1)'(1) - {1'b0, back};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    return t[AW-1:0];
  endfunction

  always_comb begin
    if (hsize_r == '0) eff_n = FW'(1);
    else if (32'(hsize_r) > 32'(HISTORY_DEPTH)) eff_n = FW'(HISTORY_DEPTH);
    else eff_n = FW'(hsize_r);
    if (maxp_r == '0) emax = LW'(1);
    else if (32'(maxp_r) > 32'(MAX_PERIOD_LIMIT)) emax = LW'(MAX_PERIOD_LIMIT);
    else emax = LW'(maxp_r);
  end

  always_comb begin
    back_a = '0;
    back_b = FW'(j_r);
    case (op)
      OP_RDL:    back_a = FW'(len_r - LW'(1));
      OP_RDPAIR: begin
        back_a = FW'(i_r);
        back_b = FW'(i_r) + FW'(len_r);
      end
      OP_RDDIST: back_a = FW'(i_r);
      OP_RDCOPY: back_a = FW'(len_r - LW'(2) - i_r);
      default:   back_a = '0;
    endcase
  end

  assign addr_a = hpos(head_r, eff_n, back_a);
  assign addr_b = hpos(head_r, eff_n, back_b);

  assign active  = (period_r != '0);
  assign stale   = (period_r > emax) || (LW'(pos_r) >= period_r);
  assign match   = (pat[pos_r] == cur_r);
  assign pos_inc = LW'(pos_r) + LW'(1);

  always_comb begin
    if (!en_r) st.ev = EV_OFF;
    else if (active && !stale && match) st.ev = EV_DROP;
    else if (active && !stale && rep_r != '0) st.ev = EV_SUM;
    else st.ev = EV_LOG;
    st.fill_ge1   = (fill_r != '0);
    st.a_eq_cur   = (rd_a_r == cur_r);
    st.a_eq_b     = (rd_a_r == rd_b_r);
    st.len_lt2    = (len_r < LW'(2));
    st.fill_short = (CW'(fill_r) + CW'(1)) < (CW'(len_r) << 1);
    st.i_last     = (LW'(i_r + LW'(1)) >= len_r) || (i_r >= len_r);
    st.j_end      = (j_r >= len_r);
    st.out_free   = !out_valid_r || out_tready;
  end

  // ring and pattern stores, no reset
  always_ff @(posedge clk) begin
    if (op == OP_FINISH) ring[head_r] <= cur_r;
    rd_a_r <= ring[addr_a];
    rd_b_r <= ring[addr_b];
    if (op == OP_CWR) pat[i_r[PW-1:0]] <= rd_a_r;
    if (op == OP_FINISH && len_r != '0) pat[PW'(len_r - LW'(1))] <= cur_r;
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) cur_r <= in_tdata[TOK_W-1:0];
    if (op == OP_EVAL) begin
      res_act_r <= ACT_LOG;
      res_cnt_r <= '0;
      res_per_r <= '0;
      if (st.ev == EV_DROP) res_act_r <= ACT_DROP;
      if (st.ev == EV_SUM) begin
        res_act_r <= ACT_SUM;
        res_cnt_r <= rep_r;
        res_per_r <= period_r;
      end
    end
    if (op == OP_OUT) out_data_r <= {1'b0, res_per_r, res_cnt_r, res_act_r};
    case (op)
      OP_SET1:     len_r <= LW'(1);
      OP_SETMAX:   len_r <= emax;
      OP_CLRLEN:   len_r <= '0;
      OP_LENDEC:   len_r <= len_r - LW'(1);
      OP_PAIRINIT, OP_COPYINIT: i_r <= '0;
      OP_INCI, OP_CWR: i_r <= i_r + LW'(1);
      OP_DISTINIT: begin
        i_r <= '0;
        j_r <= LW'(1);
      end
      OP_NEXTROW: begin
        i_r <= i_r + LW'(1);
        j_r <= i_r + LW'(2);
      end
      OP_INCJ:     j_r <= j_r + LW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b1;
      hsize_r     <= HSIZE_W'(64);
      maxp_r      <= MAXP_W'(8);
      head_r      <= '0;
      fill_r      <= '0;
      period_r    <= '0;
      pos_r       <= '0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: en_r <= cfg_data[0];
          CFG_HSIZE: begin
            hsize_r <= cfg_data;
            head_r  <= '0;
            fill_r  <= '0;
          end
          CFG_MAXP:   maxp_r <= cfg_data[MAXP_W-1:0];
          default: ;
        endcase
      end
      if (op == OP_EVAL && st.ev == EV_DROP) begin
        if (pos_inc == period_r) begin
          pos_r <= '0;
          if (rep_r != '1) rep_r <= rep_r + CNT_W'(1);
        end else begin
          pos_r <= pos_inc[PW-1:0];
        end
      end
      if (op == OP_FINISH) begin
        period_r <= len_r;
        pos_r    <= '0;
        rep_r    <= '0;
        head_r   <= (FW'(head_r) + FW'(1) == eff_n) ? '0 : head_r + AW'(1);
        if (fill_r < eff_n) fill_r <= fill_r + FW'(1);
      end
      if (op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

>>> rtl/periodic_repeat_suppressor.sv
// A dropped or disabled item goes through accept, evaluate and output; a logged item
// adds a period search over each tried length L between evaluate and output.
// One item at a time; the search walks the history ring through two read ports.
// The result register lets the next item be taken while a result waits.
// Reset (rst_n, synchronous, active low) clears control state; stores are not cleared.
`default_nettype none
module periodic_repeat_suppressor
  import prs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_W-1:0]    in_tdata,   // message_hash, severity, module_tag
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_W-1:0]        out_tdata,  // action, cycles_suppressed, period_reported
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [HSIZE_W-1:0] cfg_data
);
  dp_op_t     op;
  dp_status_t st;

  prs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .op        (op)
  );

  prs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

>>> rtl/prs_checker.sv
// Port-level checker for the periodic repeat suppressor, bound to the top.
// Depends on prs_pkg and periodic_repeat_suppressor_assert.svh.
`default_nettype none
`include "periodic_repeat_suppressor_assert.svh"
module prs_checker
  import prs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  `PRS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `PRS_ASSERT_NOW(a_act_code, out_tvalid, out_tdata[1:0] != 2'd3, "bad action code")
  `PRS_ASSERT_NOW(a_plain_zero, out_tvalid && out_tdata[1:0] != ACT_SUM, out_tdata[38:2] == '0, "stray summary fields")
  `PRS_ASSERT_NOW(a_sum_fields, out_tvalid && out_tdata[1:0] == ACT_SUM, out_tdata[33:2] != '0 && out_tdata[38:34] != '0, "empty summary")
  `PRS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")
endmodule

bind periodic_repeat_suppressor prs_checker u_prs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> tb/sv/prs_checker.sv
// Checker for the periodic repeat suppressor: watches the item and result channels,
// predicts each result from its own copy of the suppressor state, and counts mismatches.
// Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_tb_checker
  import prs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [HSIZE_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);
  typedef struct packed {
    logic [4:0]  per;
    logic [31:0] cnt;
    logic [1:0]  act;
  } verdict_t;

  token_t     ring [HISTORY_DEPTH];
  token_t     pat [MAX_PERIOD_LIMIT];
  int         head, fill, plen, ppos;
  logic [31:0] reps;
  logic       en;
  int         hsize, maxp;
  verdict_t   verdicts_due[$];

  function automatic int eff_size();
    if (hsize == 0) return 1;
    if (hsize > HISTORY_DEPTH) return HISTORY_DEPTH;
    return hsize;
  endfunction

  function automatic int eff_max();
    if (maxp == 0) return 1;
    if (maxp > MAX_PERIOD_LIMIT) return MAX_PERIOD_LIMIT;
    return maxp;
  endfunction

  function automatic token_t back_tok(int b);
    int n;
    n = eff_size();
    return ring[(head % n + n - 1 - (b % n)) % n];
  endfunction

  function automatic int find_period(token_t cur);
    bit ok;
    if (fill >= 1 && back_tok(0) == cur) begin
      pat[0] = cur;
      return 1;
    end
    for (int len = eff_max(); len >= 2; len--) begin
      ok = 1;
      if (fill < 2 * len - 1) continue;
      if (back_tok(len - 1) != cur) continue;
      for (int i = 0; ok && i + 1 < len; i++)
        if (back_tok(i) != back_tok(i + len)) ok = 0;
      for (int i = 0; ok && i + 1 < len; i++)
        for (int j = i + 1; ok && j < len; j++)
          if (back_tok(i) == back_tok(j)) ok = 0;
      if (!ok) continue;
      for (int i = 0; i + 1 < len; i++) pat[i] = back_tok(len - 2 - i);
      pat[len - 1] = cur;
      return len;
    end
    return 0;
  endfunction

  function automatic void log_tok(token_t cur);
    int len, n;
    len = find_period(cur);
    ppos = 0;
    reps = 0;
    plen = len;
    n = eff_size();
    ring[head % n] = cur;
    head = (head % n + 1) % n;
    if (fill < n) fill++;
  endfunction

  function automatic verdict_t suppress_step(token_t cur);
    verdict_t v;
    v = '0;
    if (!en) return v;
    if (plen > 0) begin
      if (plen > eff_max() || ppos >= plen) begin
        plen = 0; ppos = 0; reps = 0;
      end else if (pat[ppos] == cur) begin
        ppos = (ppos + 1) % plen;
        if (ppos == 0 && reps != 32'hFFFF_FFFF) reps++;
        v.act = ACT_DROP;
        return v;
      end else if (reps > 0) begin
        v.act = ACT_SUM;
        v.cnt = reps;
        v.per = plen[4:0];
        log_tok(cur);
        return v;
      end else begin
        plen = 0; ppos = 0; reps = 0;
      end
    end
    log_tok(cur);
    return v;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    verdict_t exp_v, got_v;
    if (!rst_n) begin
      head = 0; fill = 0; plen = 0; ppos = 0; reps = 0;
      en = 1; hsize = 64; maxp = 8;
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: en = cfg_data[0];
          CFG_HSIZE: begin
            hsize = cfg_data;
            head = 0;
            fill = 0;
          end
          CFG_MAXP: maxp = cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got_v = out_tdata[38:0];
        if (verdicts_due.size() == 0) report("unexpected item", got_v, 0);
        else begin
          exp_v = verdicts_due.pop_front();
          if (got_v.act != exp_v.act) report("action", got_v.act, exp_v.act);
          if (got_v.cnt != exp_v.cnt) report("cycles_suppressed", got_v.cnt, exp_v.cnt);
          if (got_v.per != exp_v.per) report("period_reported", got_v.per, exp_v.per);
        end
      end
      if (in_tvalid && in_tready)
        verdicts_due.push_back(suppress_step(in_tdata[TOK_W-1:0]));
    end
    pending = verdicts_due.size();
  end
endmodule

>>> tb/sv/tb.sv
// Top of the periodic repeat suppressor testbench: clock, reset, item stimulus with
// idle and stall phases, register writes between phases, and the verdict.
// Depends on prs_pkg, prs_tb_checker and the periodic_repeat_suppressor RTL.
`timescale 1ns / 1ps
module tb;
  import prs_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid, in_tready;
  logic [IN_W-1:0]    in_tdata;
  logic               out_tvalid, out_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [HSIZE_W-1:0] cfg_data;
  int                 fail_count, pending;
  int                 send_idle_pct, recv_stall_pct;
  int                 quiet_cycles;
  token_t             alphabet[16];

  periodic_repeat_suppressor i_dut (.*);

  prs_tb_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // in_tvalid stays high after an accept until the next send or an explicit drop
  task automatic send_token(token_t tok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W-TOK_W){1'b0}}, tok};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[HSIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic token_t rand_token();
    return TOK_W'({$urandom(), $urandom()});
  endfunction

  function automatic void new_alphabet();
    for (int i = 0; i < 16; i++) begin
      alphabet[i] = rand_token();
      if ($urandom_range(3) == 0) alphabet[i][34:0] = alphabet[0][34:0];
    end
  endfunction

  // mostly repeating runs of a random period, occasionally broken
  task automatic pattern_burst(int count);
    int per, k;
    per = $urandom_range(1, 17);
    k = 0;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(19))
        0: send_token(rand_token());
        1: send_token(alphabet[$urandom_range(15)]);
        2: begin
          per = $urandom_range(1, 17);
          k = 0;
          send_token(alphabet[k % 16]);
        end
        default: send_token(alphabet[(k % per) % 16]);
      endcase
      k++;
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, period 1 and 3 runs, break after repeats, items while disabled
    send_token('0);
    send_token('1);
    send_token('1);
    send_token('1);
    send_token('0);
    for (int i = 0; i < 3; i++) send_token({16'hFFFF, 3'd0, 32'h0});
    for (int i = 0; i < 9; i++) send_token({16'd1, 3'd7, 32'd10 + 32'(i % 3)});
    send_token({16'd1, 3'd6, 32'd10});
    send_token({16'd2, 3'd7, 32'd10});
    send_token({16'd1, 3'd7, 32'd11});
    write_reg(CFG_ENABLE, 0);
    send_token('1);
    send_token('1);
    write_reg(CFG_ENABLE, 1);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      case (phase)
        1: write_reg(CFG_MAXP, 16);
        2: write_reg(CFG_HSIZE, 1);
        3: write_reg(CFG_MAXP, 1);
        4: write_reg(CFG_HSIZE, $urandom_range(2, 40));
        5: write_reg(CFG_MAXP, 0);
        6: write_reg(CFG_HSIZE, 0);
        7: begin
          write_reg(CFG_HSIZE, 127);
          write_reg(CFG_MAXP, 31);
        end
        default: ;
      endcase
      if (phase == 4 || phase == 6) write_reg(CFG_MAXP, $urandom_range(2, 16));
      new_alphabet();
      pattern_burst(190);
      if (phase == 5) begin
        write_reg(CFG_ENABLE, 0);
        pattern_burst(10);
        write_reg(CFG_ENABLE, 1);
        write_reg(CFG_HSIZE, 64);
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
